/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// condition that must never hold, off during reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

/* rtl/pam_pkg.sv */
package pam_pkg;

  // default geometry
  localparam int NUM_PAGES_DEF  = 1024;
  localparam int PAGE_SHIFT_DEF = 12;

  // field widths
  localparam int ADDR_W    = 48;
  localparam int LEN_W     = 23;
  localparam int PERM_W    = 3;
  localparam int CNT_W     = 11;
  localparam int FLAG_W    = 4;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 1;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [LEN_W-1:0] BYTES_MAX = 23'h7FFFFF;

  // request codes
  localparam logic [REQ_W-1:0] REQ_MAP    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BSS    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RUN    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES = 1'b1;

  // page flag bits
  localparam logic [FLAG_W-1:0] FL_MAPPED = 4'b0001;
  localparam logic [FLAG_W-1:0] FL_READ   = 4'b0010;
  localparam logic [FLAG_W-1:0] FL_WRITE  = 4'b0100;
  localparam logic [FLAG_W-1:0] FL_EXEC   = 4'b1000;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] vaddr;
    logic [LEN_W-1:0]  length;
    logic [PERM_W-1:0] seg_perms;
    logic [CNT_W-1:0]  max_pages;
  } pam_item_t;

  typedef struct packed {
    logic              valid_res;
    logic [FLAG_W-1:0] page_flags_out;
    logic [LEN_W-1:0]  run_bytes;
  } pam_result_t;

  // classified work handed from front to back
  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic              in_image;
    logic [CNT_W-1:0]  first;
    logic [CNT_W-1:0]  start_pg;
    logic [CNT_W-1:0]  stop;
    logic [FLAG_W-1:0] flags;
    logic [LEN_W-1:0]  bytes0;
  } pam_task_t;

  typedef struct packed {
    logic clearing;
  } pam_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_FLAG,
    ST_RUN
  } pam_state_t;

  // segment x/w/r bits to page flags
  function automatic logic [FLAG_W-1:0] perms_to_flags(input logic [PERM_W-1:0] perms);
    logic [FLAG_W-1:0] f;
    f = FL_MAPPED;
    if (perms[0]) f = f | FL_EXEC;
    if (perms[1]) f = f | FL_WRITE;
    if (perms[2]) f = f | FL_READ;
    return f;
  endfunction

endpackage

/* rtl/pam_front.sv */
module pam_front #(
  parameter int NUM_PAGES  = pam_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = pam_pkg::PAGE_SHIFT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  pam_pkg::pam_item_t                 item,
  output logic                               busy,
  input  logic                               cfg_wen,
  input  logic [pam_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pam_pkg::ADDR_W-1:0]         cfg_wdata,
  input  pam_pkg::pam_status_t               status,
  input  logic                               q_full,
  output logic                               push,
  output pam_pkg::pam_task_t                 push_task
);

  localparam int AW = pam_pkg::ADDR_W;
  localparam int CW = pam_pkg::CNT_W;
  localparam int LN = pam_pkg::LEN_W;
  localparam int OW = CW + PAGE_SHIFT;
  localparam int EW = ((OW > LN) ? OW : LN) + 1;
  localparam int LW = EW - PAGE_SHIFT + 1;
  localparam int PAGE_BYTES = 1 << PAGE_SHIFT;

  logic [AW-1:0] base_address;
  logic [CW-1:0] image_pages;
  logic [CW-1:0] live_pages;

  logic                           f_vld;
  logic [pam_pkg::REQ_W-1:0]      f_req;
  logic                           f_in_image;
  logic [OW-1:0]                  f_off;
  logic [LN-1:0]                  f_len;
  logic [pam_pkg::PERM_W-1:0]     f_perms;
  logic [CW-1:0]                  f_maxp;

  logic [AW-1:0] offset;
  logic          in_image_now;
  logic          accept;

  logic [CW-1:0]             first;
  logic [PAGE_SHIFT-1:0]     part;
  logic                      part_nz;
  logic [EW-1:0]             end_ofs;
  logic [LW-1:0]             last;
  logic [CW-1:0]             stop_map;
  logic [CW-1:0]             idx;
  logic [CW:0]               lim;
  logic [CW-1:0]             stop_run;
  logic                      is_map;
  logic [pam_pkg::FLAG_W-1:0] map_flags;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      image_pages  <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        pam_pkg::CFG_BASE:  base_address <= cfg_wdata;
        pam_pkg::CFG_PAGES: image_pages  <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // image size clipped to the store depth
  assign live_pages = (NUM_PAGES < (1 << CW) && int'(image_pages) > NUM_PAGES)
                      ? CW'(NUM_PAGES) : image_pages;

  // address test at accept
  assign offset       = item.vaddr - base_address;
  assign in_image_now = (offset >> PAGE_SHIFT) < AW'(live_pages);

  assign busy   = status.clearing || (f_vld && q_full);
  assign accept = start && !busy;
  assign push   = f_vld && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (accept) begin
      f_vld <= 1'b1;
    end else if (push) begin
      f_vld <= 1'b0;
    end
  end

  // captured transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      f_req      <= item.req_type;
      f_in_image <= in_image_now;
      f_off      <= offset[OW-1:0];
      f_len      <= item.length;
      f_perms    <= item.seg_perms;
      f_maxp     <= item.max_pages;
    end
  end

  // page range of a map request
  assign first    = f_off[OW-1:PAGE_SHIFT];
  assign part     = f_off[PAGE_SHIFT-1:0];
  assign part_nz  = |part;
  assign end_ofs  = EW'(f_off) + EW'(f_len);
  assign last     = LW'(end_ofs >> PAGE_SHIFT) + LW'(|end_ofs[PAGE_SHIFT-1:0]);
  assign stop_map = (last > LW'(live_pages)) ? live_pages : last[CW-1:0];

  // page range of a run request
  assign idx      = first + CW'(part_nz);
  assign lim      = (CW+1)'(idx) + (CW+1)'(f_maxp);
  assign stop_run = (lim > (CW+1)'(live_pages)) ? live_pages : lim[CW-1:0];

  assign is_map    = (f_req == pam_pkg::REQ_MAP) || (f_req == pam_pkg::REQ_BSS);
  assign map_flags = (f_req == pam_pkg::REQ_MAP) ? pam_pkg::perms_to_flags(f_perms)
                     : (pam_pkg::FL_MAPPED | pam_pkg::FL_READ | pam_pkg::FL_WRITE);

  always_comb begin
    push_task.req      = f_req;
    push_task.in_image = f_in_image;
    push_task.first    = first;
    push_task.start_pg = is_map ? first : idx;
    push_task.stop     = is_map ? stop_map : stop_run;
    push_task.flags    = map_flags;
    push_task.bytes0   = part_nz ? (LN'(PAGE_BYTES) - LN'(part)) : '0;
  end

endmodule

/* rtl/pam_queue.sv */
`include "assert_macros.svh"

module pam_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pam_pkg::pam_task_t wdata,
  output logic               full,
  input  logic               pop,
  output pam_pkg::pam_task_t rdata,
  output logic               empty
);

  localparam int DEPTH = pam_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pam_pkg::pam_task_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

  `ASSERT_IMPLY(a_push_room, clk, rst, push, !full, "queue push while full")
  `ASSERT_IMPLY(a_pop_data, clk, rst, pop, !empty, "queue pop while empty")

endmodule

/* rtl/pam_back.sv */
`include "assert_macros.svh"

module pam_back #(
  parameter int NUM_PAGES  = pam_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = pam_pkg::PAGE_SHIFT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pam_pkg::pam_task_t   head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 done,
  output pam_pkg::pam_result_t result,
  output pam_pkg::pam_status_t status
);

  localparam int CN = pam_pkg::CNT_W;
  localparam int FW = pam_pkg::FLAG_W;
  localparam int LN = pam_pkg::LEN_W;
  localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int XW = (PW > CN) ? PW : CN;
  localparam int PAGE_BYTES = 1 << PAGE_SHIFT;

  // page count to store index
  function automatic logic [PW-1:0] to_idx(input logic [CN-1:0] p);
    logic [XW-1:0] w;
    w = XW'(p);
    return w[PW-1:0];
  endfunction

  logic [FW-1:0] mem [NUM_PAGES];
  logic [FW-1:0] rdata;
  logic [PW-1:0] raddr;
  logic [PW-1:0] waddr;
  logic [FW-1:0] wdata;
  logic          we;

  pam_pkg::pam_state_t  state, state_next;
  logic [PW-1:0]        clr_cnt, clr_cnt_next;
  pam_pkg::pam_task_t   cur, cur_next;
  logic [CN-1:0]        ptr, ptr_next;
  logic                 rd_pend, rd_pend_next;
  logic [FW-1:0]        flags_ref, flags_ref_next;
  logic [LN-1:0]        bytes, bytes_next;
  logic                 done_next;
  pam_pkg::pam_result_t result_next;

  logic          mism;
  logic [LN:0]   sum;
  logic [LN-1:0] acc;

  // page flag store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pam_pkg::ST_CLEAR;
      clr_cnt <= '0;
      rd_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      rd_pend <= rd_pend_next;
      done    <= done_next;
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    cur       <= cur_next;
    ptr       <= ptr_next;
    flags_ref <= flags_ref_next;
    bytes     <= bytes_next;
    result    <= result_next;
  end

  // run compare and saturating byte count
  assign mism = rd_pend && (rdata != flags_ref);
  assign sum  = {1'b0, bytes} + (LN+1)'(PAGE_BYTES);
  assign acc  = !rd_pend ? bytes
                : ((sum > (LN+1)'(pam_pkg::BYTES_MAX)) ? pam_pkg::BYTES_MAX : sum[LN-1:0]);

  // sequencer
  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    cur_next       = cur;
    ptr_next       = ptr;
    rd_pend_next   = rd_pend;
    flags_ref_next = flags_ref;
    bytes_next     = bytes;
    done_next      = 1'b0;
    result_next    = result;
    pop            = 1'b0;
    we             = 1'b0;
    waddr          = to_idx(ptr);
    wdata          = cur.flags;
    raddr          = to_idx(ptr);

    unique case (state)
      pam_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
        if (clr_cnt == PW'(NUM_PAGES - 1)) begin
          state_next = pam_pkg::ST_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + 1'b1;
        end
      end

      pam_pkg::ST_IDLE: begin
        raddr = to_idx(head.first);
        if (!empty) begin
          pop      = 1'b1;
          cur_next = head;
          if (!head.in_image) begin
            done_next   = 1'b1;
            result_next = '0;
          end else begin
            case (head.req) inside
              pam_pkg::REQ_MAP, pam_pkg::REQ_BSS: begin
                ptr_next   = head.start_pg;
                state_next = pam_pkg::ST_MAP;
              end
              default: begin
                state_next = pam_pkg::ST_FLAG;
              end
            endcase
          end
        end
      end

      pam_pkg::ST_MAP: begin
        if (ptr < cur.stop) begin
          we       = 1'b1;
          ptr_next = ptr + 1'b1;
        end else begin
          done_next   = 1'b1;
          result_next = '{valid_res: 1'b1, page_flags_out: cur.flags, run_bytes: '0};
          state_next  = pam_pkg::ST_IDLE;
        end
      end

      pam_pkg::ST_FLAG: begin
        flags_ref_next = rdata;
        if (cur.req == pam_pkg::REQ_LOOKUP) begin
          done_next   = 1'b1;
          result_next = '{valid_res: 1'b1, page_flags_out: rdata, run_bytes: '0};
          state_next  = pam_pkg::ST_IDLE;
        end else begin
          ptr_next     = cur.start_pg;
          rd_pend_next = 1'b0;
          bytes_next   = cur.bytes0;
          state_next   = pam_pkg::ST_RUN;
        end
      end

      pam_pkg::ST_RUN: begin
        if (mism) begin
          done_next    = 1'b1;
          result_next  = '{valid_res: 1'b1, page_flags_out: flags_ref, run_bytes: bytes};
          rd_pend_next = 1'b0;
          state_next   = pam_pkg::ST_IDLE;
        end else begin
          bytes_next = acc;
          if (ptr < cur.stop) begin
            ptr_next     = ptr + 1'b1;
            rd_pend_next = 1'b1;
          end else begin
            done_next    = 1'b1;
            result_next  = '{valid_res: 1'b1, page_flags_out: flags_ref, run_bytes: acc};
            rd_pend_next = 1'b0;
            state_next   = pam_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_next = pam_pkg::ST_IDLE;
      end
    endcase
  end

  assign status.clearing = (state == pam_pkg::ST_CLEAR);

  `ASSERT_IMPLY(a_no_done_clear, clk, rst, state == pam_pkg::ST_CLEAR, !done, "result during clear")
  `ASSERT_IMPLY(a_pend_in_run, clk, rst, rd_pend, $past(state == pam_pkg::ST_RUN), "stray read pending")
  `ASSERT_IMPLY(a_miss_zero, clk, rst, done && !result.valid_res, result.page_flags_out == '0 && result.run_bytes == '0, "outside result not zero")

endmodule

/* rtl/page_attribute_map.sv */
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+--------------------------
// request   | in        | start high, busy low | item   (pam_item_t)
// result    | out       | done, one cycle      | result (pam_result_t)
// config    | in        | cfg_wen              | cfg_index, cfg_wdata
//
// after reset the store is cleared one page per cycle; busy stays high until
// it is clear. the sequencer does one store read or write per cycle: map
// writes its pages, lookup reads one flag, run compares its pages, and a
// request outside the image gets a zero result. the intake register and the
// two-entry queue keep busy low while the sequencer works, until both are
// full. done pulses for one cycle per request; the receiver cannot stall it.
module page_attribute_map #(
  parameter int NUM_PAGES  = pam_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = pam_pkg::PAGE_SHIFT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  pam_pkg::pam_item_t            item,
  output logic                          busy,
  output logic                          done,
  output pam_pkg::pam_result_t          result,
  input  logic                          cfg_wen,
  input  logic [pam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pam_pkg::ADDR_W-1:0]    cfg_wdata
);

  pam_pkg::pam_status_t status;
  pam_pkg::pam_task_t   push_task;
  pam_pkg::pam_task_t   head;
  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 q_empty;

  // request intake and classification
  pam_front #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .status    (status),
    .q_full    (q_full),
    .push      (push),
    .push_task (push_task)
  );

  // work queue
  pam_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_task),
    .full  (q_full),
    .pop   (pop),
    .rdata (head),
    .empty (q_empty)
  );

  // page store sequencer
  pam_back #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .done   (done),
    .result (result),
    .status (status)
  );

endmodule
